### rtl/ipv4e_pkg.sv
// ----------------------------------------------------------------------------
// ipv4e_pkg
// Shared types, codes and byte-placement functions for the IPv4-embedded
// IPv6 address translator.
// ----------------------------------------------------------------------------
package ipv4e_pkg;

  localparam int AddrHalfW = 64;
  localparam int AddrW     = 2 * AddrHalfW;
  localparam int V4W       = 32;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 64;
  localparam int LenW      = 8;

  // Direction codes.
  localparam logic CMD_6TO4 = 1'b0;
  localparam logic CMD_4TO6 = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DROP    = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PREFIX_HIGH   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PREFIX_LOW    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PREFIX_LENGTH = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FALLBACK_V4   = 2'd3;

  // Allowed prefix lengths in bits.
  localparam logic [LenW-1:0] PLEN_32 = 8'd32;
  localparam logic [LenW-1:0] PLEN_40 = 8'd40;
  localparam logic [LenW-1:0] PLEN_48 = 8'd48;
  localparam logic [LenW-1:0] PLEN_56 = 8'd56;
  localparam logic [LenW-1:0] PLEN_64 = 8'd64;
  localparam logic [LenW-1:0] PLEN_96 = 8'd96;
  localparam logic [LenW-1:0] PLEN_RESET = PLEN_96;

  typedef enum logic [2:0] {
    LEN_32,
    LEN_40,
    LEN_48,
    LEN_56,
    LEN_64,
    LEN_96,
    LEN_BAD
  } len_code_t;

  typedef struct packed {
    logic                 cmd;
    logic [AddrHalfW-1:0] src6_high;
    logic [AddrHalfW-1:0] src6_low;
    logic [AddrHalfW-1:0] dst6_high;
    logic [AddrHalfW-1:0] dst6_low;
    logic [V4W-1:0]       src4;
    logic [V4W-1:0]       dst4;
    logic                 icmp6_error;
  } in_t;

  typedef struct packed {
    logic [AddrHalfW-1:0] out_src6_high;
    logic [AddrHalfW-1:0] out_src6_low;
    logic [AddrHalfW-1:0] out_dst6_high;
    logic [AddrHalfW-1:0] out_dst6_low;
    logic [V4W-1:0]       out_src4;
    logic [V4W-1:0]       out_dst4;
    logic [1:0]           status;
  } out_t;

  function automatic len_code_t decode_len(input logic [LenW-1:0] len);
    len_code_t code;
    unique case (len)
      PLEN_32: code = LEN_32;
      PLEN_40: code = LEN_40;
      PLEN_48: code = LEN_48;
      PLEN_56: code = LEN_56;
      PLEN_64: code = LEN_64;
      PLEN_96: code = LEN_96;
      default: code = LEN_BAD;
    endcase
    return code;
  endfunction

  // Mask over the first prefix-length bits of a 128-bit address.
  function automatic logic [AddrW-1:0] prefix_mask(input len_code_t code);
    logic [AddrW-1:0] m;
    unique case (code)
      LEN_32:  m = {{32{1'b1}}, {96{1'b0}}};
      LEN_40:  m = {{40{1'b1}}, {88{1'b0}}};
      LEN_48:  m = {{48{1'b1}}, {80{1'b0}}};
      LEN_56:  m = {{56{1'b1}}, {72{1'b0}}};
      LEN_64:  m = {{64{1'b1}}, {64{1'b0}}};
      LEN_96:  m = {{96{1'b1}}, {32{1'b0}}};
      default: m = '0;
    endcase
    return m;
  endfunction

  // Pull the embedded IPv4 address out; byte 8 (bits 63:56) is skipped.
  function automatic logic [V4W-1:0] extract_v4(input len_code_t code,
                                                input logic [AddrW-1:0] a);
    logic [V4W-1:0] v;
    unique case (code)
      LEN_32:  v = a[95:64];
      LEN_40:  v = {a[87:64], a[55:48]};
      LEN_48:  v = {a[79:64], a[55:40]};
      LEN_56:  v = {a[71:64], a[55:32]};
      LEN_64:  v = a[55:24];
      LEN_96:  v = a[31:0];
      default: v = '0;
    endcase
    return v;
  endfunction

  // Place an IPv4 address at the byte positions for the prefix length.
  function automatic logic [AddrW-1:0] place_v4(input len_code_t code,
                                                input logic [V4W-1:0] v);
    logic [AddrW-1:0] a;
    a = '0;
    unique case (code)
      LEN_32:  a[95:64] = v;
      LEN_40:  begin
        a[87:64] = v[31:8];
        a[55:48] = v[7:0];
      end
      LEN_48:  begin
        a[79:64] = v[31:16];
        a[55:40] = v[15:0];
      end
      LEN_56:  begin
        a[71:64] = v[31:24];
        a[55:32] = v[23:0];
      end
      LEN_64:  a[55:24] = v;
      LEN_96:  a[31:0] = v;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/ipv4_embedded_ipv6_translator.sv
// ----------------------------------------------------------------------------
// ipv4_embedded_ipv6_translator
// Translates a source/destination address pair between IPv6 and IPv4 using a
// configured translation prefix of 32, 40, 48, 56, 64 or 96 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one address pair per
//   beat together with the direction and the ICMPv6 error flag. Output
//   channel (out_valid/out_ready/out_data) returns one result beat per input
//   beat, in order, with a status code.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   prefix halves, the prefix length and the fallback IPv4 source. It is
//   always ready; write it only while no beats are in flight.
//   The beat passes three register stages: length decode, prefix match with
//   byte extraction/placement, then status resolution into the output
//   register. The valid bit moves from v1 through v2 to v3, which drives
//   out_valid. Throughput is one beat per cycle while out_ready stays high.
//   Reset clears all stage valid bits and loads the configuration registers
//   with their defaults (zero prefix, length 96, zero fallback).
//   When the receiver stalls, each stage holds its beat and keeps accepting
//   until the stage after it is full, so in_ready drops only after all three
//   stages are occupied.
// ----------------------------------------------------------------------------
module ipv4_embedded_ipv6_translator
  import ipv4e_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers.
  logic [AddrHalfW-1:0] prefix_high;
  logic [AddrHalfW-1:0] prefix_low;
  logic [LenW-1:0]      prefix_length;
  logic [V4W-1:0]       fallback_v4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_high   <= '0;
      prefix_low    <= '0;
      prefix_length <= PLEN_RESET;
      fallback_v4   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PREFIX_HIGH:   prefix_high   <= cfg_data;
        CFG_PREFIX_LOW:    prefix_low    <= cfg_data;
        CFG_PREFIX_LENGTH: prefix_length <= cfg_data[LenW-1:0];
        CFG_FALLBACK_V4:   fallback_v4   <= cfg_data[V4W-1:0];
      endcase
    end
  end

  // Stage handshakes: a stage loads when it is empty or its beat moves on.
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  // Stage 1: capture the beat and decode the prefix length.
  in_t       s1_data;
  len_code_t s1_len;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_data <= in_data;
      s1_len  <= decode_len(prefix_length);
    end
  end

  // Stage 2: prefix match, IPv4 extraction and IPv6 construction.
  logic [AddrW-1:0] pfx;
  logic [AddrW-1:0] s1_mask;
  logic [AddrW-1:0] s1_src6;
  logic [AddrW-1:0] s1_dst6;

  assign pfx     = {prefix_high, prefix_low};
  assign s1_mask = prefix_mask(s1_len);
  assign s1_src6 = {s1_data.src6_high, s1_data.src6_low};
  assign s1_dst6 = {s1_data.dst6_high, s1_data.dst6_low};

  logic             s2_cmd;
  logic             s2_icmp;
  logic             s2_bad;
  logic             s2_src_miss;
  logic             s2_dst_miss;
  logic [V4W-1:0]   s2_src4;
  logic [V4W-1:0]   s2_dst4;
  logic [AddrW-1:0] s2_src6;
  logic [AddrW-1:0] s2_dst6;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_cmd      <= s1_data.cmd;
      s2_icmp     <= s1_data.icmp6_error;
      s2_bad      <= (s1_len == LEN_BAD);
      s2_src_miss <= |((s1_src6 ^ pfx) & s1_mask);
      s2_dst_miss <= |((s1_dst6 ^ pfx) & s1_mask);
      s2_src4     <= extract_v4(s1_len, s1_src6);
      s2_dst4     <= extract_v4(s1_len, s1_dst6);
      s2_src6     <= (pfx & s1_mask) | place_v4(s1_len, s1_data.src4);
      s2_dst6     <= (pfx & s1_mask) | place_v4(s1_len, s1_data.dst4);
    end
  end

  // Stage 3: resolve status and zero the fields that are not produced.
  out_t s2_result;

  always_comb begin
    s2_result = '0;
    priority if (s2_bad) begin
      s2_result.status = STATUS_BAD_LEN;
    end else if (s2_cmd == CMD_4TO6) begin
      s2_result.out_src6_high = s2_src6[AddrW-1:AddrHalfW];
      s2_result.out_src6_low  = s2_src6[AddrHalfW-1:0];
      s2_result.out_dst6_high = s2_dst6[AddrW-1:AddrHalfW];
      s2_result.out_dst6_low  = s2_dst6[AddrHalfW-1:0];
      s2_result.status        = STATUS_OK;
    end else if ((s2_src_miss && !s2_icmp) || s2_dst_miss) begin
      s2_result.status = STATUS_DROP;
    end else begin
      // An untranslatable ICMPv6 error source takes the fallback address.
      s2_result.out_src4 = s2_src_miss ? fallback_v4 : s2_src4;
      s2_result.out_dst4 = s2_dst4;
      s2_result.status   = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_data <= s2_result;
    end
  end

  assign out_valid = v3;

  // Assertions.
  a_accept_fills_stage1 : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted beat did not enter stage 1");

  a_status_known : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_DROP ||
                   out_data.status == STATUS_BAD_LEN))
    else $error("unknown status code");

  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != STATUS_OK) |->
      (out_data.out_src4 == '0 && out_data.out_dst4 == '0 &&
       out_data.out_src6_high == '0 && out_data.out_src6_low == '0 &&
       out_data.out_dst6_high == '0 && out_data.out_dst6_low == '0))
    else $error("failed translation carries nonzero address fields");

  a_one_direction : assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((out_data.out_src4 == '0 && out_data.out_dst4 == '0) ||
       (out_data.out_src6_high == '0 && out_data.out_src6_low == '0 &&
        out_data.out_dst6_high == '0 && out_data.out_dst6_low == '0)))
    else $error("both IPv4 and IPv6 result fields are populated");

  a_stall_holds_pipe : assert property (@(posedge clk) disable iff (rst)
    (v3 && !out_ready && v2) |=> (v3 && v2))
    else $error("stalled pipeline lost a beat");

endmodule
